@@ rtl/crm_pkg.sv @@
// ----------------------------------------------------------------------------
// crm_pkg
// Shared constants of the colour ramp mapper: register indexes and ramp codes.
// ----------------------------------------------------------------------------
`default_nettype none

package crm_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_LOW_BOUND   = 2'd0;
    localparam logic [1:0] REG_HIGH_BOUND  = 2'd1;
    localparam logic [1:0] REG_RAMP_SELECT = 2'd2;

    // Width of the ramp select register.
    localparam int RAMP_BITS = 5;

    // Ramp numbers. Every other code gives white.
    localparam logic [RAMP_BITS-1:0] RAMP_JET       = 5'd1;
    localparam logic [RAMP_BITS-1:0] RAMP_BLUE_RED  = 5'd2;
    localparam logic [RAMP_BITS-1:0] RAMP_GRAY      = 5'd3;
    localparam logic [RAMP_BITS-1:0] RAMP_HUE       = 5'd4;
    localparam logic [RAMP_BITS-1:0] RAMP_SPRING    = 5'd5;
    localparam logic [RAMP_BITS-1:0] RAMP_MAGENTA   = 5'd6;
    localparam logic [RAMP_BITS-1:0] RAMP_WAVE      = 5'd7;
    localparam logic [RAMP_BITS-1:0] RAMP_TENT      = 5'd8;
    localparam logic [RAMP_BITS-1:0] RAMP_VIOLET    = 5'd9;
    localparam logic [RAMP_BITS-1:0] RAMP_SPECTRUM  = 5'd10;
    localparam logic [RAMP_BITS-1:0] RAMP_BROWN     = 5'd11;
    localparam logic [RAMP_BITS-1:0] RAMP_EARTH     = 5'd12;
    localparam logic [RAMP_BITS-1:0] RAMP_TERRAIN   = 5'd13;
    localparam logic [RAMP_BITS-1:0] RAMP_AUTUMN    = 5'd14;
    localparam logic [RAMP_BITS-1:0] RAMP_JET_WHITE = 5'd15;
    localparam logic [RAMP_BITS-1:0] RAMP_BGR       = 5'd16;
    localparam logic [RAMP_BITS-1:0] RAMP_RMB       = 5'd17;
    localparam logic [RAMP_BITS-1:0] RAMP_WINTER    = 5'd18;
    localparam logic [RAMP_BITS-1:0] RAMP_COOL      = 5'd19;
    localparam logic [RAMP_BITS-1:0] RAMP_FIELD     = 5'd20;
    localparam logic [RAMP_BITS-1:0] RAMP_PASTEL    = 5'd21;
    localparam logic [RAMP_BITS-1:0] RAMP_DUSK      = 5'd22;
    localparam logic [RAMP_BITS-1:0] RAMP_RED_WHITE = 5'd23;
    localparam logic [RAMP_BITS-1:0] RAMP_SUNSET    = 5'd24;
    localparam logic [RAMP_BITS-1:0] RAMP_OCEAN     = 5'd25;

    // Extra bits of the numerator and denominator words over the sample width.
    localparam int FRAC_GROWTH = 13;

endpackage

`default_nettype wire

@@ rtl/crm_position.sv @@
// ----------------------------------------------------------------------------
// crm_position
// Orders and widens the bounds, clips the sample and registers its offset
// from the low bound together with the span of the range.
// ----------------------------------------------------------------------------
`default_nettype none

module crm_position #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [SAMPLE_BITS-1:0] i_low_bound,
    input  wire logic signed [SAMPLE_BITS-1:0] i_high_bound,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_value,
    output logic             [SAMPLE_BITS-1:0] o_offset,
    output logic             [SAMPLE_BITS-1:0] o_span
);
    import crm_pkg::*;

    localparam int XW = SAMPLE_BITS + 2;

    logic signed [XW-1:0] lo_ext;
    logic signed [XW-1:0] hi_ext;
    logic signed [XW-1:0] v_ext;
    logic signed [XW-1:0] lo_ord;
    logic signed [XW-1:0] hi_ord;
    logic signed [XW-1:0] v_clip;
    logic signed [XW-1:0] off_full;
    logic signed [XW-1:0] span_full;
    logic [SAMPLE_BITS-1:0] r_offset;
    logic [SAMPLE_BITS-1:0] r_span;

    // Sort the bounds, widen equal ones, then clip the sample.
    always_comb begin
        lo_ext = XW'(i_low_bound);
        hi_ext = XW'(i_high_bound);
        v_ext  = XW'(i_sample_value);
        if (hi_ext < lo_ext) begin
            lo_ord = hi_ext;
            hi_ord = lo_ext;
        end else begin
            lo_ord = lo_ext;
            hi_ord = hi_ext;
        end
        if (hi_ord == lo_ord) begin
            lo_ord = lo_ord - XW'(1);
            hi_ord = hi_ord + XW'(1);
        end
        if (v_ext < lo_ord) begin
            v_clip = lo_ord;
        end else if (v_ext > hi_ord) begin
            v_clip = hi_ord;
        end else begin
            v_clip = v_ext;
        end
        off_full  = v_clip - lo_ord;
        span_full = hi_ord - lo_ord;
    end

    // Both values stay below two to the sample width.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_offset <= off_full[SAMPLE_BITS-1:0];
            r_span   <= span_full[SAMPLE_BITS-1:0];
        end
    end

    assign o_offset = r_offset;
    assign o_span   = r_span;

endmodule

`default_nettype wire

@@ rtl/crm_segment.sv @@
// ----------------------------------------------------------------------------
// crm_segment
// Picks the ramp segment for the sample position and registers each colour
// component as an exact fraction: three numerators over one denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module crm_segment #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                             i_clk,
    input  wire logic                                             i_en,
    input  wire logic [crm_pkg::RAMP_BITS-1:0]                    i_ramp_select,
    input  wire logic [SAMPLE_BITS-1:0]                           i_offset,
    input  wire logic [SAMPLE_BITS-1:0]                           i_span,
    output logic signed [SAMPLE_BITS+crm_pkg::FRAC_GROWTH-1:0]    o_num [3],
    output logic signed [SAMPLE_BITS+crm_pkg::FRAC_GROWTH-1:0]    o_den
);
    import crm_pkg::*;

    localparam int AW = SAMPLE_BITS + FRAC_GROWTH;

    // Product of a word and a small constant.
    function automatic logic signed [AW-1:0] km(input logic signed [AW-1:0] x, input int k);
        logic signed [AW-1:0] kk;
        kk = AW'(k);
        return x * kk;
    endfunction

    // Numerator of a blend between two stops given in 0..255 units.
    function automatic logic signed [AW-1:0] blend(input int a, input int c,
                                                   input logic signed [AW-1:0] tn,
                                                   input logic signed [AW-1:0] td);
        return km(td, a) + km(tn, c - a);
    endfunction

    logic signed [AW-1:0] n;
    logic signed [AW-1:0] d;
    logic signed [AW-1:0] n2, n3, n4, n5, n6, n10;
    logic signed [AW-1:0] d2, d3, d4, d5, d6, d7;
    logic signed [AW-1:0] a0, a1, a2, den;
    logic signed [AW-1:0] r_num [3];
    logic signed [AW-1:0] r_den;

    always_comb begin
        n   = AW'(i_offset);
        d   = AW'(i_span);
        n2  = km(n, 2);
        n3  = km(n, 3);
        n4  = km(n, 4);
        n5  = km(n, 5);
        n6  = km(n, 6);
        n10 = km(n, 10);
        d2  = km(d, 2);
        d3  = km(d, 3);
        d4  = km(d, 4);
        d5  = km(d, 5);
        d6  = km(d, 6);
        d7  = km(d, 7);
        a0  = AW'(1);
        a1  = AW'(1);
        a2  = AW'(1);
        den = AW'(1);

        // Segment tests are exact integer compares on the scaled offset.
        case (i_ramp_select)
            RAMP_JET: begin
                den = d;
                if (n4 < d) begin
                    a0 = '0; a1 = n4; a2 = d;
                end else if (n2 < d) begin
                    a0 = '0; a1 = d; a2 = d2 - n4;
                end else if (n4 < d3) begin
                    a0 = n4 - d2; a1 = d; a2 = '0;
                end else begin
                    a0 = d; a1 = d4 - n4; a2 = '0;
                end
            end
            RAMP_BLUE_RED: begin
                den = d; a0 = n; a1 = '0; a2 = d - n;
            end
            RAMP_GRAY: begin
                den = d; a0 = n; a1 = n; a2 = n;
            end
            RAMP_HUE: begin
                den = d;
                if (n6 < d) begin
                    a0 = d; a1 = n6; a2 = '0;
                end else if (n6 < d2) begin
                    a0 = d2 - n6; a1 = d; a2 = '0;
                end else if (n6 < d3) begin
                    a0 = '0; a1 = d; a2 = n6 - d2;
                end else if (n6 < d4) begin
                    a0 = '0; a1 = d4 - n6; a2 = d;
                end else if (n6 < d5) begin
                    a0 = n6 - d4; a1 = '0; a2 = d;
                end else begin
                    a0 = d; a1 = '0; a2 = d6 - n6;
                end
            end
            RAMP_SPRING: begin
                den = d; a0 = n; a1 = d; a2 = '0;
            end
            RAMP_MAGENTA: begin
                den = d; a0 = n; a1 = d - n; a2 = n;
            end
            RAMP_WAVE: begin
                den = d;
                if (n4 < d) begin
                    a0 = '0; a1 = n4; a2 = d - n4;
                end else if (n2 < d) begin
                    a0 = n4 - d; a1 = d2 - n4; a2 = '0;
                end else if (n4 < d3) begin
                    a0 = d3 - n4; a1 = n4 - d2; a2 = '0;
                end else begin
                    a0 = '0; a1 = d4 - n4; a2 = n4 - d3;
                end
            end
            RAMP_TENT: begin
                den = d;
                if (n2 < d) begin
                    a0 = n2; a1 = n2; a2 = n2;
                end else begin
                    a0 = d2 - n2; a1 = d2 - n2; a2 = d2 - n2;
                end
            end
            RAMP_VIOLET: begin
                den = d;
                if (n3 < d) begin
                    a0 = d - n3; a1 = '0; a2 = n3;
                end else if (n3 < d2) begin
                    a0 = '0; a1 = n3 - d; a2 = d;
                end else begin
                    a0 = n3 - d2; a1 = d3 - n3; a2 = d;
                end
            end
            RAMP_SPECTRUM: begin
                den = d;
                if (n5 < d) begin
                    a0 = '0; a1 = n5; a2 = d;
                end else if (n5 < d2) begin
                    a0 = '0; a1 = d; a2 = d2 - n5;
                end else if (n5 < d3) begin
                    a0 = n5 - d2; a1 = d; a2 = '0;
                end else if (n5 < d4) begin
                    a0 = d; a1 = d4 - n5; a2 = '0;
                end else begin
                    a0 = d; a1 = n5 - d4; a2 = n5 - d4;
                end
            end
            RAMP_BROWN: begin
                den = km(d, 255);
                a0 = blend(200, 250, n, d);
                a1 = blend(60, 160, n, d);
                a2 = blend(0, 110, n, d);
            end
            RAMP_EARTH: begin
                // Knee at four tenths of the range.
                if (n10 < d4) begin
                    den = km(d4, 255);
                    a0 = blend(55, 235, n10, d4);
                    a1 = blend(55, 90, n10, d4);
                    a2 = blend(45, 30, n10, d4);
                end else begin
                    den = km(d6, 255);
                    a0 = blend(235, 250, n10 - d4, d6);
                    a1 = blend(90, 160, n10 - d4, d6);
                    a2 = blend(30, 110, n10 - d4, d6);
                end
            end
            RAMP_TERRAIN: begin
                // Knee at three tenths of the range.
                if (n10 < d3) begin
                    den = km(d3, 255);
                    a0 = blend(0, 255, n10, d3);
                    a1 = blend(255, 150, n10, d3);
                    a2 = blend(0, 0, n10, d3);
                end else begin
                    den = km(d7, 255);
                    a0 = blend(255, 255, n10 - d3, d7);
                    a1 = blend(150, 250, n10 - d3, d7);
                    a2 = blend(0, 240, n10 - d3, d7);
                end
            end
            RAMP_AUTUMN: begin
                den = d; a0 = d; a1 = d - n; a2 = '0;
            end
            RAMP_JET_WHITE: begin
                den = d;
                if (n4 < d) begin
                    a0 = '0; a1 = n4; a2 = d;
                end else if (n2 < d) begin
                    a0 = '0; a1 = d; a2 = d2 - n4;
                end else if (n4 < d3) begin
                    a0 = n4 - d2; a1 = d; a2 = '0;
                end else begin
                    a0 = d; a1 = d; a2 = n4 - d3;
                end
            end
            RAMP_BGR: begin
                den = d;
                if (n2 < d) begin
                    a0 = '0; a1 = n2; a2 = d - n2;
                end else begin
                    a0 = n2 - d; a1 = d2 - n2; a2 = '0;
                end
            end
            RAMP_RMB: begin
                den = d;
                if (n2 < d) begin
                    a0 = d; a1 = d - n2; a2 = n2;
                end else begin
                    a0 = d2 - n2; a1 = n2 - d; a2 = d;
                end
            end
            RAMP_WINTER: begin
                den = d; a0 = '0; a1 = n; a2 = d;
            end
            RAMP_COOL: begin
                den = d; a0 = n; a1 = n; a2 = d;
            end
            RAMP_FIELD: begin
                if (n10 < d3) begin
                    den = km(d3, 255);
                    a0 = blend(0, 180, n10, d3);
                    a1 = blend(160, 220, n10, d3);
                    a2 = blend(0, 0, n10, d3);
                end else begin
                    den = km(d7, 255);
                    a0 = blend(180, 250, n10 - d3, d7);
                    a1 = blend(220, 220, n10 - d3, d7);
                    a2 = blend(0, 170, n10 - d3, d7);
                end
            end
            RAMP_PASTEL: begin
                den = km(d, 255);
                a0 = blend(255, 150, n, d);
                a1 = blend(255, 150, n, d);
                a2 = blend(200, 255, n, d);
            end
            RAMP_DUSK: begin
                den = d; a0 = d - n; a1 = d - n; a2 = n;
            end
            RAMP_RED_WHITE: begin
                den = d;
                if (n2 < d) begin
                    a0 = d; a1 = n2; a2 = n2;
                end else begin
                    a0 = d2 - n2; a1 = d2 - n2; a2 = d;
                end
            end
            RAMP_SUNSET: begin
                den = d;
                if (n2 < d) begin
                    a0 = n2; a1 = n2; a2 = d - n2;
                end else begin
                    a0 = d; a1 = d2 - n2; a2 = '0;
                end
            end
            RAMP_OCEAN: begin
                den = d;
                if (n3 < d) begin
                    a0 = '0; a1 = n3; a2 = d;
                end else if (n3 < d2) begin
                    a0 = n3 - d; a1 = d2 - n3; a2 = d;
                end else begin
                    a0 = d; a1 = '0; a2 = d3 - n3;
                end
            end
            default: begin
                // Unknown ramp: full scale on every component, which is white.
                den = AW'(1); a0 = AW'(1); a1 = AW'(1); a2 = AW'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= a0;
            r_num[1] <= a1;
            r_num[2] <= a2;
            r_den    <= den;
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;

endmodule

`default_nettype wire

@@ rtl/crm_divider.sv @@
// ----------------------------------------------------------------------------
// crm_divider
// Pipelined restoring divider for one component. It scales the fraction
// num/den to the colour range, one quotient bit per stage, and rounds halves
// up in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crm_divider #(
    parameter int SAMPLE_BITS = 16,
    parameter int COLOUR_BITS = 8
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_en,
    input  wire logic signed [SAMPLE_BITS+crm_pkg::FRAC_GROWTH-1:0] i_num,
    input  wire logic signed [SAMPLE_BITS+crm_pkg::FRAC_GROWTH-1:0] i_den,
    output logic [COLOUR_BITS-1:0]                             o_level
);
    import crm_pkg::*;

    localparam int AW = SAMPLE_BITS + FRAC_GROWTH;
    localparam int QW = COLOUR_BITS + 1;
    localparam int NW = AW + QW;
    localparam logic [COLOUR_BITS-1:0] LEVEL_MAX = {COLOUR_BITS{1'b1}};

    logic [NW-1:0] num_u;
    logic [NW-1:0] scaled;

    logic [AW-1:0]          r_rem  [QW+1];
    logic [QW-1:0]          r_low  [QW+1];
    logic [AW-1:0]          r_den  [QW+1];
    logic [QW-1:0]          r_quo  [QW+1];
    logic                   r_zero [QW+1];
    logic                   r_full [QW+1];
    logic [COLOUR_BITS-1:0] r_level;
    logic [QW-1:0]          quo_rnd;

    // Scale by twice the full-scale level: (2^QW - 2) * num.
    always_comb begin
        num_u  = NW'(i_num[AW-1:0]);
        scaled = (num_u << QW) - (num_u << 1);
    end

    // Entry stage: the top bits of the scaled numerator are below den when num is below den.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= scaled[NW-1:QW];
            r_low[0]  <= scaled[QW-1:0];
            r_den[0]  <= i_den[AW-1:0];
            r_quo[0]  <= '0;
            r_zero[0] <= (i_num <= AW'(0));
            r_full[0] <= (i_num >= i_den);
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [AW:0] trial;
        logic        fits;

        always_comb begin
            trial = {r_rem[k], r_low[k][QW-1-k]};
            fits  = (trial >= {1'b0, r_den[k]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= fits ? AW'(trial - {1'b0, r_den[k]}) : trial[AW-1:0];
                r_low[k+1]  <= r_low[k];
                r_den[k+1]  <= r_den[k];
                r_quo[k+1]  <= r_quo[k] | (QW'(fits) << (QW-1-k));
                r_zero[k+1] <= r_zero[k];
                r_full[k+1] <= r_full[k];
            end
        end
    end

    // Halve the doubled quotient with rounding; the result stays in range.
    assign quo_rnd = r_quo[QW] + QW'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[QW]) begin
                r_level <= '0;
            end else if (r_full[QW]) begin
                r_level <= LEVEL_MAX;
            end else begin
                r_level <= quo_rnd[QW-1:1];
            end
        end
    end

    assign o_level = r_level;

endmodule

`default_nettype wire

@@ rtl/colour_ramp_mapper_core.sv @@
// ----------------------------------------------------------------------------
// colour_ramp_mapper_core
// False-colour mapper: one signed sample in, one RGB word out, through one of
// twenty-five piecewise-linear colour ramps chosen by a register.
//
//   Channel | Signals                                        | Direction
//   --------+------------------------------------------------+----------
//   input   | i_in_valid, o_in_stall, i_sample_value         | in
//   output  | o_out_valid, i_out_stall, o_red/green/blue_... | out
//   config  | i_cfg_we, i_cfg_index, i_cfg_data              | in
//
// One word is taken every cycle unless stalled. Words pass the position and
// segment registers, then the divider, one quotient bit per stage.
// Reset clears the valid bits and loads the register defaults.
// A stall at the output freezes the whole pipeline while a finished word
// waits there; the input stall follows it, so no word is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module colour_ramp_mapper_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int COLOUR_BITS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [SAMPLE_BITS-1:0]        i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [COLOUR_BITS-1:0]             o_red_level,
    output logic [COLOUR_BITS-1:0]             o_green_level,
    output logic [COLOUR_BITS-1:0]             o_blue_level
);
    import crm_pkg::*;

    localparam int AW  = SAMPLE_BITS + FRAC_GROWTH;
    localparam int LAT = COLOUR_BITS + 5;
    localparam logic [SAMPLE_BITS-1:0] HIGH_RESET = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    logic signed [SAMPLE_BITS-1:0] r_low_bound;
    logic signed [SAMPLE_BITS-1:0] r_high_bound;
    logic [RAMP_BITS-1:0]          r_ramp_select;
    logic [LAT-1:0]                r_vld;
    logic                          en;
    logic [SAMPLE_BITS-1:0]        offset;
    logic [SAMPLE_BITS-1:0]        span;
    logic signed [AW-1:0]          num [3];
    logic signed [AW-1:0]          den;
    logic [COLOUR_BITS-1:0]        level [3];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_bound   <= '0;
            r_high_bound  <= HIGH_RESET;
            r_ramp_select <= RAMP_JET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LOW_BOUND:   r_low_bound   <= i_cfg_data;
                REG_HIGH_BOUND:  r_high_bound  <= i_cfg_data;
                REG_RAMP_SELECT: r_ramp_select <= i_cfg_data[RAMP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves unless a finished word is held at the output.
    assign en         = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall = !en;

    // Valid bits travel alongside the data stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    crm_position #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_position (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_low_bound    (r_low_bound),
        .i_high_bound   (r_high_bound),
        .i_sample_value (i_sample_value),
        .o_offset       (offset),
        .o_span         (span)
    );

    crm_segment #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_segment (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_ramp_select (r_ramp_select),
        .i_offset      (offset),
        .i_span        (span),
        .o_num         (num),
        .o_den         (den)
    );

    // One divider lane per colour component.
    for (genvar c = 0; c < 3; c++) begin : g_lane
        crm_divider #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .COLOUR_BITS(COLOUR_BITS)
        ) u_divider (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_num   (num[c]),
            .i_den   (den),
            .o_level (level[c])
        );
    end

    assign o_out_valid   = r_vld[LAT-1];
    assign o_red_level   = level[0];
    assign o_green_level = level[1];
    assign o_blue_level  = level[2];

endmodule

`default_nettype wire
